### rtl/yenc_pkg.sv
// ----------------------------------------------------------------------------
// yenc_pkg
// Shared constants and types for the yEnc line encoder: character codes,
// register defaults and the command word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package yenc_pkg;

    localparam int unsigned COL_W          = 10;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam logic [7:0] SHIFT_ADD   = 8'd42;
    localparam logic [7:0] ESC_ADD     = 8'd64;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ESC    = 8'h3D;

    localparam logic [COL_W-1:0] LINE_LEN_RESET = COL_W'(128);

    // One classified input byte: shifted value and how to emit it.
    typedef struct packed {
        logic [7:0] value;     // byte after the +42 shift
        logic       esc;       // emit as escape pair
        logic       line_end;  // follow with CR LF
        logic       eob;       // last byte of the caller's buffer
    } t_cmd;

endpackage

`default_nettype wire

### rtl/yenc_front.sv
// ----------------------------------------------------------------------------
// yenc_front
// Accepts input bytes, shifts and classifies them against the running column
// and the line length register, and pushes one command per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module yenc_front
    import yenc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_end_of_buffer,
    input  wire logic             i_cfg_valid,
    input  wire logic [COL_W-1:0] i_line_length,
    input  wire logic             i_queue_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [COL_W-1:0] r_column;
    logic [COL_W-1:0] n_column;
    logic [COL_W-1:0] r_line_length;
    logic [7:0]       shifted;
    logic             at_start;
    logic             at_edge;
    logic             critical;
    logic             white;
    logic             esc;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        shifted  = i_data_byte + SHIFT_ADD;
        at_start = (r_column == '0);
        at_edge  = ({1'b0, r_column} + (COL_W+1)'(1)) >= {1'b0, r_line_length};
        critical = (shifted == CHAR_NUL) || (shifted == CHAR_LF) ||
                   (shifted == CHAR_CR)  || (shifted == CHAR_ESC);
        white    = (shifted == CHAR_TAB) || (shifted == CHAR_SPACE);
        esc      = critical || ((at_start || at_edge) && white) ||
                   (at_start && (shifted == CHAR_DOT));
        if (at_edge) begin
            n_column = '0;
        end else begin
            n_column = r_column + (esc ? COL_W'(2) : COL_W'(1));
        end
    end

    assign o_cmd.value    = shifted;
    assign o_cmd.esc      = esc;
    assign o_cmd.line_end = at_edge;
    assign o_cmd.eob      = i_end_of_buffer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column      <= '0;
            r_line_length <= LINE_LEN_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_line_length <= i_line_length;
            end
            if (o_push) begin
                r_column <= n_column;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/yenc_queue.sv
// ----------------------------------------------------------------------------
// yenc_queue
// Small command queue between front and back; register storage, head shown
// combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module yenc_queue
    import yenc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_head_valid,
    output t_cmd      o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/yenc_back.sv
// ----------------------------------------------------------------------------
// yenc_back
// Expands each command into one to four output characters through a
// registered output stage, one beat per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module yenc_back
    import yenc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_head_valid,
    input  t_cmd            i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_buffer_end
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state     r_state;
    t_cmd       r_cmd;
    logic [1:0] r_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic       r_buffer_end;
    logic       load;
    logic       head_last;
    logic       run_last;

    // Beat k of a command: [ESC, value+64 | value] then [CR, LF].
    function automatic logic [7:0] beat_char(input t_cmd c, input logic [1:0] k);
        logic [7:0] esc_val;
        logic [7:0] ch;
        esc_val = c.value + ESC_ADD;
        if (c.esc) begin
            unique case (k)
                2'd0: ch = CHAR_ESC;
                2'd1: ch = esc_val;
                2'd2: ch = CHAR_CR;
                2'd3: ch = CHAR_LF;
            endcase
        end else begin
            unique case (k)
                2'd0:    ch = c.value;
                2'd1:    ch = CHAR_CR;
                default: ch = CHAR_LF;
            endcase
        end
        return ch;
    endfunction

    // Index of the final beat: escape adds one, line end adds two.
    function automatic logic [1:0] last_step(input t_cmd c);
        return {c.line_end, c.esc};
    endfunction

    assign load      = !r_out_valid || !i_out_stall;
    assign o_pop     = load && (r_state == ST_IDLE) && i_head_valid;
    assign head_last = (last_step(i_head) == 2'd0);
    assign run_last  = (r_step == last_step(r_cmd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else if (load) begin
            unique case (r_state)
                ST_RUN: begin
                    r_out_valid  <= 1'b1;
                    r_out_byte   <= beat_char(r_cmd, r_step);
                    r_run_last   <= run_last;
                    r_buffer_end <= run_last && r_cmd.eob;
                    r_step       <= r_step + 2'd1;
                    if (run_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_out_valid <= i_head_valid;
                    if (i_head_valid) begin
                        r_out_byte   <= beat_char(i_head, 2'd0);
                        r_run_last   <= head_last;
                        r_buffer_end <= head_last && i_head.eob;
                        r_cmd        <= i_head;
                        r_step       <= 2'd1;
                        if (!head_last) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_buffer_end = r_buffer_end;

endmodule

`default_nettype wire

### rtl/yenc_line_encoder.sv
// ----------------------------------------------------------------------------
// yenc_line_encoder
// yEnc encoder with line wrapping: raw bytes in, encoded characters out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one raw byte per beat
//   (i_data_byte, i_end_of_buffer). Output channel: o_out_valid / i_out_stall
//   carry one encoded character per beat (o_out_byte, o_run_last on the last
//   character of a byte, o_buffer_end on the last character of a byte that
//   was flagged end of buffer).
//   Config channel: i_cfg_valid / o_cfg_ready write i_line_length; write only
//   while the encoder is drained. o_cfg_ready is always high.
//   With the queue empty, a byte is classified and written into the queue
//   when it is accepted; its first character is then loaded from the queue
//   head into the output register. Throughput: the output side moves one
//   character per cycle while the receiver does not stall, so a byte occupies
//   the back end for one to four characters (plain, escaped, plus CR LF at a
//   line end). The front takes one byte per cycle while the queue has room.
//   Reset clears the column to start of line, line length to 128 and empties
//   the queue. When the receiver stalls, the output register holds its beat,
//   the queue fills, and o_in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module yenc_line_encoder
    import yenc_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // raw byte channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_end_of_buffer,
    // encoded character channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last,
    output logic                  o_buffer_end,
    // line length register
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [COL_W-1:0] i_line_length
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic queue_full;
    logic head_valid;
    logic pop;

    assign o_cfg_ready = 1'b1;

    // Front: shift, pick the escape set from the column, advance the column.
    yenc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .i_cfg_valid    (i_cfg_valid),
        .i_line_length  (i_line_length),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // Queue decouples classification from character emission.
    yenc_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_head_valid(head_valid),
        .o_head      (head_cmd)
    );

    // Back: expand each command into its characters.
    yenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_buffer_end(o_buffer_end)
    );

endmodule

`default_nettype wire

### rtl/yenc_checker.sv
// ----------------------------------------------------------------------------
// yenc_checker
// Port-level checks on the encoded character stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module yenc_checker
    import yenc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_run_last,
    input wire logic       o_buffer_end
);

    logic out_beat;
    assign out_beat = o_out_valid && !i_out_stall;

    // A stalled beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("output beat changed under stall");

    // Buffer end only marks the last character of a byte.
    a_eob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_buffer_end |-> o_run_last)
        else $error("buffer_end without run_last");

    // An escape lead character never ends a byte's run.
    a_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_byte == CHAR_ESC) |-> !o_run_last)
        else $error("escape character ended a run");

    // A bare CR is always a line break and LF follows directly, closing the run.
    a_crlf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && (o_out_byte == CHAR_CR) |=>
            o_out_valid && (o_out_byte == CHAR_LF) && o_run_last)
        else $error("CR not followed by LF");

endmodule

bind yenc_line_encoder yenc_checker u_yenc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last),
    .o_buffer_end(o_buffer_end)
);

`default_nettype wire
